FILE: rtl/icc_pkg.sv
// ----------------------------------------------------------------------------
// icc_pkg: shared types and constants of the interval OR census
// Field widths of both channels, default mask width and the control states.
// ----------------------------------------------------------------------------
package icc_pkg;

  // default number of mask bits
  localparam int MASK_BITS_DEF = 17;

  // fixed payload widths
  localparam int LETTER_W = 17;
  localparam int GAIN_W   = 5;
  localparam int UNC_W    = 17;
  localparam int LEN_W    = 5;

  // control sequence of one letter
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_HOLD
  } icc_state_t;

endpackage

FILE: rtl/icc_in_if.sv
// ----------------------------------------------------------------------------
// icc_in_if: letter channel
// Valid/ready channel carrying one mask letter per transfer.
// ----------------------------------------------------------------------------
interface icc_in_if;
  logic                         valid;
  logic                         ready;
  logic [icc_pkg::LETTER_W-1:0] letter;

  modport source (output valid, output letter, input ready);
  modport sink   (input valid, input letter, output ready);
endinterface

FILE: rtl/icc_out_if.sv
// ----------------------------------------------------------------------------
// icc_out_if: census result channel
// Valid/ready channel carrying one census result per transfer.
// ----------------------------------------------------------------------------
interface icc_out_if;
  logic                       valid;
  logic                       ready;
  logic [icc_pkg::GAIN_W-1:0] gain;
  logic [icc_pkg::UNC_W-1:0]  uncovered_left;
  logic [icc_pkg::LEN_W-1:0]  chain_length;
  logic                       bad_letter;

  modport source (output valid, output gain, output uncovered_left,
                  output chain_length, output bad_letter, input ready);
  modport sink   (input valid, input gain, input uncovered_left,
                  input chain_length, input bad_letter, output ready);
endinterface

FILE: rtl/icc_ram.sv
// ----------------------------------------------------------------------------
// icc_ram: generic simple dual-port RAM
// One write port and one read port; read data registered, old data on a
// same-address collision.
// ----------------------------------------------------------------------------
module icc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/interval_or_coverage_census.sv
// ----------------------------------------------------------------------------
// interval_or_coverage_census: census of distinct interval OR masks
// Keeps the chain of distinct ORs of the intervals ending at the last letter
// and a seen-map of every mask that has been some interval's OR.
//
//   channel | dir | payload                                         | handshake
//   in_ch   | in  | letter                                          | valid/ready
//   out_ch  | out | gain, uncovered_left, chain_length, bad_letter  | valid/ready
//
// Sequence: a nonzero letter walks the chain (n = chain length before it, at
// most MASK_BITS) with at most one seen-map read per walk step, then the drain
// state makes the last mark and the hold state loads the result; a zero letter
// goes straight to the hold state, and the next letter is taken back in idle.
// Reset: a clearing pass over every seen-map address empties it, ready low.
// Stalls: a stalled result holds in the output register; the next one waits.
// ----------------------------------------------------------------------------
module interval_or_coverage_census #(
  parameter int MASK_BITS = icc_pkg::MASK_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  icc_in_if.sink    in_ch,
  icc_out_if.source out_ch
);

  localparam int CW = $clog2(MASK_BITS + 1);
  localparam int IW = $clog2(MASK_BITS);
  localparam int DEPTH = 1 << MASK_BITS;

  icc_pkg::icc_state_t state_r, state_nxt;

  logic [MASK_BITS-1:0] clr_r;
  logic [MASK_BITS-1:0] letter_r;
  logic [MASK_BITS-1:0] old_r;
  logic [MASK_BITS-1:0] last_r;
  logic [MASK_BITS-1:0] chain_r [MASK_BITS];
  logic [CW-1:0]        k_r;
  logic [CW-1:0]        n_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        gain_r;
  logic [MASK_BITS-1:0] unseen_r;
  logic                 bad_r;
  logic                 pend_r;
  logic [MASK_BITS-1:0] pend_addr_r;
  logic                 fwd_r;

  logic                 out_valid_r;
  logic [icc_pkg::GAIN_W-1:0] out_gain_r;
  logic [icc_pkg::UNC_W-1:0]  out_unc_r;
  logic [icc_pkg::LEN_W-1:0]  out_len_r;
  logic                       out_bad_r;

  logic [icc_pkg::LETTER_W+MASK_BITS-1:0] letter_ext;
  logic [icc_pkg::UNC_W+MASK_BITS-1:0]    unseen_ext;
  logic [MASK_BITS-1:0] letter_in;
  logic [MASK_BITS-1:0] cand;
  logic                 keep;
  logic                 last_step;
  logic                 newly;
  logic                 in_xfer;
  logic                 slot_free;

  logic                 ram_we;
  logic [MASK_BITS-1:0] ram_waddr;
  logic                 ram_wdata;
  logic                 ram_re;
  logic                 ram_rdata;

  // fit letter and count to their widths
  assign letter_ext = {{MASK_BITS{1'b0}}, in_ch.letter};
  assign letter_in  = letter_ext[MASK_BITS-1:0];
  assign unseen_ext = {{icc_pkg::UNC_W{1'b0}}, unseen_r};

  // candidate of the current walk step
  assign cand      = (k_r == '0) ? letter_r : (old_r | letter_r);
  assign keep      = (k_r == '0) || ((cand != last_r) && (n_r < CW'(MASK_BITS)));
  assign last_step = (k_r == cnt_r);
  assign newly     = pend_r && !ram_rdata && !fwd_r;
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icc_pkg::ST_CLEAR: begin
        if (clr_r == '1) state_nxt = icc_pkg::ST_IDLE;
      end
      icc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (letter_in == '0) ? icc_pkg::ST_HOLD : icc_pkg::ST_WALK;
        end
      end
      icc_pkg::ST_WALK: begin
        if (last_step) state_nxt = icc_pkg::ST_DRAIN;
      end
      icc_pkg::ST_DRAIN: begin
        state_nxt = icc_pkg::ST_HOLD;
      end
      icc_pkg::ST_HOLD: begin
        if (slot_free) state_nxt = icc_pkg::ST_IDLE;
      end
      default: state_nxt = icc_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer: handshake and seen-map ports
  always_comb begin
    in_ch.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_r;
    ram_wdata   = 1'b1;
    unique case (state_r)
      icc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
      end
      icc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      icc_pkg::ST_WALK: begin
        ram_re = keep;
        ram_we = newly;
      end
      icc_pkg::ST_DRAIN: begin
        ram_we = newly;
      end
      icc_pkg::ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // seen-map
  icc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_seen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cand),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= icc_pkg::ST_CLEAR;
      clr_r    <= '0;
      cnt_r    <= '0;
      unseen_r <= '1;
      pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == icc_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      // mark a newly seen mask
      if (newly) begin
        if (unseen_r != '0) unseen_r <= unseen_r - 1'b1;
      end
      if (state_r == icc_pkg::ST_WALK) begin
        pend_r <= keep;
        if (last_step) cnt_r <= n_r + CW'(keep);
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      letter_r <= letter_in;
      k_r      <= '0;
      n_r      <= '0;
      gain_r   <= '0;
      bad_r    <= (letter_in == '0);
    end else begin
      if (newly) gain_r <= gain_r + 1'b1;
      if (state_r == icc_pkg::ST_WALK) begin
        k_r <= k_r + 1'b1;
        // fetch the next old entry before it can be overwritten
        if (k_r < cnt_r) old_r <= chain_r[k_r[IW-1:0]];
        if (keep) begin
          chain_r[n_r[IW-1:0]] <= cand;
          last_r               <= cand;
          n_r                  <= n_r + 1'b1;
        end
      end
    end
    // read and write of one address in the same cycle: the mark wins
    pend_addr_r <= cand;
    fwd_r       <= ram_re && ram_we && (ram_waddr == cand);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == icc_pkg::ST_HOLD && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == icc_pkg::ST_HOLD && slot_free) begin
      out_gain_r <= icc_pkg::GAIN_W'(gain_r);
      out_unc_r  <= unseen_ext[icc_pkg::UNC_W-1:0];
      out_len_r  <= icc_pkg::LEN_W'(cnt_r);
      out_bad_r  <= bad_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.gain           = out_gain_r;
  assign out_ch.uncovered_left = out_unc_r;
  assign out_ch.chain_length   = out_len_r;
  assign out_ch.bad_letter     = out_bad_r;

  // chain never outgrows the mask width
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MASK_BITS))
    else $error("chain count above mask width");

  // a result is loaded only from the hold state
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == icc_pkg::ST_HOLD))
    else $error("result loaded outside hold state");

  // a good letter leaves a nonempty chain
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.bad_letter) |-> (out_ch.chain_length != '0))
    else $error("empty chain after a good letter");

  // gain is bounded by the chain it came from
  a_gain_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.gain <= out_ch.chain_length))
    else $error("gain exceeds chain length");

  // no marking write while the seen-map is being cleared
  a_no_mark_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == icc_pkg::ST_CLEAR) |-> !pend_r)
    else $error("mark pending during clearing pass");

endmodule

FILE: bench/interval_or_coverage_census_tb.sv
// ----------------------------------------------------------------------------
// interval_or_coverage_census_tb: self-checking bench of the interval OR census
// Feeds mask letters over the letter channel: a directed run through zero
// letters, full and single-bit letters and a chain grown to full length,
// then sparse-biased random letters. A census tally keeps its own suffix OR
// chain and seen-map, predicts each result and checks every result transfer
// in order. Both channels idle in random bursts, with a quiet final stretch.
// ----------------------------------------------------------------------------
module interval_or_coverage_census_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MASK_W         = icc_pkg::MASK_BITS_DEF;
  localparam int MAP_SIZE       = 1 << MASK_W;
  localparam int RANDOM_LETTERS = 1800;
  localparam int QUIET_TAIL     = 300;
  localparam int DRAIN_CYCLES   = 40;
  // clearing pass of the seen-map plus the slowest letter, taken three times
  localparam int WATCHDOG_LIMIT = 3 * (MAP_SIZE + 64);

  typedef struct packed {
    logic [icc_pkg::GAIN_W-1:0] gain;
    logic [icc_pkg::UNC_W-1:0]  uncovered_left;
    logic [icc_pkg::LEN_W-1:0]  chain_length;
    logic                       bad_letter;
  } census_t;

  // Census tally: own chain, seen-map and the queue of expected results
  class census_tally;
    bit [MASK_W-1:0] suffix_or [MASK_W];
    int unsigned     chain_len;
    bit              seen_map [MAP_SIZE];
    int unsigned     unseen = MAP_SIZE - 1;
    census_t         pending_census [$];
    int unsigned     failures;

    // Rebuild the chain for one accepted letter and queue its census
    function void note_letter(input logic [icc_pkg::LETTER_W-1:0] raw);
      bit [MASK_W-1:0] letter;
      bit [MASK_W-1:0] fresh [MASK_W];
      bit [MASK_W-1:0] v;
      int unsigned     n;
      int unsigned     gain;
      census_t         want;
      letter = raw[MASK_W-1:0];
      gain   = 0;
      if (letter == '0) begin
        want.gain           = '0;
        want.uncovered_left = unseen[icc_pkg::UNC_W-1:0];
        want.chain_length   = chain_len[icc_pkg::LEN_W-1:0];
        want.bad_letter     = 1'b1;
        pending_census.insert(pending_census.size(), want);
        return;
      end
      fresh[0] = letter;
      n        = 1;
      // extend each older interval by the letter, drop repeats
      for (int i = 0; i < chain_len && i < MASK_W; i++) begin
        v = suffix_or[i] | letter;
        if (v != fresh[n-1] && n < MASK_W) begin
          fresh[n] = v;
          n++;
        end
      end
      // mark masks witnessed for the first time
      for (int i = 0; i < MASK_W; i++) begin
        if (i < n) begin
          suffix_or[i] = fresh[i];
          if (!seen_map[fresh[i]]) begin
            seen_map[fresh[i]] = 1'b1;
            gain++;
            if (unseen > 0) unseen--;
          end
        end else begin
          suffix_or[i] = '0;
        end
      end
      chain_len           = n;
      want.gain           = gain[icc_pkg::GAIN_W-1:0];
      want.uncovered_left = unseen[icc_pkg::UNC_W-1:0];
      want.chain_length   = chain_len[icc_pkg::LEN_W-1:0];
      want.bad_letter     = 1'b0;
      pending_census.insert(pending_census.size(), want);
    endfunction

    task report(input string msg);
      $display("[%0t] census mismatch: %s", $realtime, msg);
      failures++;
    endtask

    // Compare one result transfer with the oldest expectation
    task check_census(input census_t got);
      census_t want;
      if (pending_census.size() == 0) begin
        report($sformatf("result with nothing expected (gain %0d left %0d len %0d bad %0b)",
                         got.gain, got.uncovered_left, got.chain_length, got.bad_letter));
        return;
      end
      want = pending_census.pop_front();
      if (got.gain !== want.gain)
        report($sformatf("gain got %0d want %0d", got.gain, want.gain));
      if (got.uncovered_left !== want.uncovered_left)
        report($sformatf("uncovered_left got %0d want %0d",
                         got.uncovered_left, want.uncovered_left));
      if (got.chain_length !== want.chain_length)
        report($sformatf("chain_length got %0d want %0d",
                         got.chain_length, want.chain_length));
      if (got.bad_letter !== want.bad_letter)
        report($sformatf("bad_letter got %0b want %0b", got.bad_letter, want.bad_letter));
    endtask
  endclass

  logic clk;
  logic rst_n;

  icc_in_if  in_ch ();
  icc_out_if out_ch ();

  interval_or_coverage_census dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  census_tally tally;
  bit          letter_gaps;
  bit          result_stalls;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one letter and hold it until the transfer
  task automatic send_letter(input logic [icc_pkg::LETTER_W-1:0] letter);
    if (letter_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.letter <= letter;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tally.note_letter(letter);
    @(negedge clk);
  endtask

  // Mostly sparse letters so that chains grow long, with zeros and dense noise
  function automatic logic [icc_pkg::LETTER_W-1:0] pick_letter();
    int unsigned roll;
    logic [icc_pkg::LETTER_W-1:0] l;
    roll = $urandom_range(0, 99);
    l    = '0;
    if (roll < 6) begin
      l = '0;
    end else if (roll < 60) begin
      l[$urandom_range(0, MASK_W-1)] = 1'b1;
    end else if (roll < 82) begin
      l[$urandom_range(0, MASK_W-1)] = 1'b1;
      l[$urandom_range(0, MASK_W-1)] = 1'b1;
    end else begin
      l = icc_pkg::LETTER_W'($urandom());
    end
    return l;
  endfunction

  // Result side: ready with random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (result_stalls && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tally.check_census({out_ch.gain, out_ch.uncovered_left,
                          out_ch.chain_length, out_ch.bad_letter});
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("interval_or_coverage_census_tb: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [icc_pkg::LETTER_W-1:0] directed [$];
    tally         = new;
    letter_gaps   = 1'b0;
    result_stalls = 1'b0;
    stall_left    = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.letter  = '0;
    out_ch.ready  = 1'b0;

    // hold reset, then release it
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: lowest and highest letters, zeros, a full-length chain, then two alternating-bit letters
    directed = '{17'h00001, 17'h00000, 17'h10000, 17'h1FFFF, 17'h00000};
    for (int b = 0; b < MASK_W; b++)
      directed.insert(directed.size(), icc_pkg::LETTER_W'(1) << b);
    directed.insert(directed.size(), 17'h00000);
    directed.insert(directed.size(), 17'h15555);
    directed.insert(directed.size(), 17'h0AAAA);
    foreach (directed[k]) send_letter(directed[k]);

    // random: change idling mode every 150 letters, quiet at the end
    for (int k = 0; k < RANDOM_LETTERS; k++) begin
      if (k >= RANDOM_LETTERS - QUIET_TAIL) begin
        letter_gaps   = 1'b0;
        result_stalls = 1'b0;
      end else if (k % 150 == 0) begin
        letter_gaps   = $urandom_range(0, 2) != 0;
        result_stalls = $urandom_range(0, 2) != 0;
      end
      send_letter(pick_letter());
    end
    in_ch.valid <= 1'b0;

    // drain outstanding results, then allow for stragglers
    while (tally.pending_census.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tally.failures == 0)
      $display("interval_or_coverage_census_tb: PASS");
    else
      $display("interval_or_coverage_census_tb: FAIL");
    $finish;
  end

endmodule
